// ===== design/bsdm_pkg.sv =====
`default_nettype none

package bsdm_pkg;

    localparam logic [1:0] OP_COUNT   = 2'd0;
    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_LOAD    = 2'd3;

    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] digit_index;
        logic [3:0] digit_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  digit_select;
        logic [6:0]  segments;
        logic        dot;
        logic [15:0] count_bcd;
    } result_t;

    // bit0 a through bit6 g, 1 = lit; out-of-range codes show as nine
    function automatic logic [6:0] seg_decode(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            default: s = 7'h6F;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== design/bsdm_update.sv =====
`default_nettype none

module bsdm_update #(
    parameter int NUM_DIGITS = 4,
    parameter int SEL_W      = 2
) (
    input  bsdm_pkg::item_t               item,
    input  logic [NUM_DIGITS-1:0][3:0]    digits_cur,
    input  logic [SEL_W-1:0]              sel_cur,
    output logic [NUM_DIGITS-1:0][3:0]    digits_next,
    output logic [SEL_W-1:0]              sel_next,
    output bsdm_pkg::result_t             result
);

    logic [3:0]  sel_digit;
    logic [15:0] bcd_w;
    logic [1:0]  select_w;

    always_comb
    begin
        logic       carry;
        logic       hit;
        logic [3:0] load_val;
        digits_next = digits_cur;
        sel_next    = sel_cur;
        carry       = 1'b0;
        hit         = 1'b0;
        load_val    = (item.digit_value > bsdm_pkg::DIGIT_MAX) ? bsdm_pkg::DIGIT_MAX
                                                               : item.digit_value;
        unique case (item.operation)
            bsdm_pkg::OP_COUNT:
            begin
                // ripple from the start digit toward digit 0; digit 0 wraps
                for (int i = NUM_DIGITS - 1; i >= 0; i--)
                begin
                    hit = carry || ({2'b00, item.digit_index} == 4'(i));
                    if (hit)
                    begin
                        digits_next[i] = (digits_cur[i] >= bsdm_pkg::DIGIT_MAX)
                                         ? 4'd0 : digits_cur[i] + 4'd1;
                    end
                    carry = hit && (digits_cur[i] == bsdm_pkg::DIGIT_MAX) && (i != 0);
                end
            end
            bsdm_pkg::OP_REFRESH:
            begin
                sel_next = (sel_cur == SEL_W'(NUM_DIGITS - 1)) ? '0 : sel_cur + SEL_W'(1);
            end
            bsdm_pkg::OP_CLEAR:
            begin
                digits_next = '0;
            end
            bsdm_pkg::OP_LOAD:
            begin
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    if ({2'b00, item.digit_index} == 4'(i))
                    begin
                        digits_next[i] = load_val;
                    end
                end
            end
            default:
            begin
                digits_next = digits_cur;
            end
        endcase
    end

    always_comb
    begin
        sel_digit = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (sel_next == SEL_W'(i))
            begin
                sel_digit = digits_next[i];
            end
        end
    end

    // digit 0 lands in the top nibble; only the four low-order digits fit
    for (genvar k = 0; k < 4; k++)
    begin : g_bcd
        if (k < NUM_DIGITS)
        begin : g_used
            assign bcd_w[4*k +: 4] = digits_next[NUM_DIGITS-1-k];
        end
        else
        begin : g_pad
            assign bcd_w[4*k +: 4] = 4'd0;
        end
    end

    if (SEL_W >= 2)
    begin : g_sel_wide
        assign select_w = sel_next[1:0];
    end
    else
    begin : g_sel_narrow
        assign select_w = {1'b0, sel_next};
    end

    assign result.digit_select = select_w;
    assign result.segments     = bsdm_pkg::seg_decode(sel_digit);
    assign result.dot          = (sel_next == SEL_W'(1));
    assign result.count_bcd    = bcd_w;

endmodule

`default_nettype wire

// ===== design/bcd_stopwatch_display_mux.sv =====
// Multiplexed BCD counter with seven-segment decode. Each input transaction
// (count tick, refresh tick, clear, load) yields exactly one result transaction
// showing the selected digit index, its segment pattern, the dot and the packed
// count after the operation. One transaction is taken every cycle when the
// output side keeps up; a transaction passes through the input register, then
// the digit update and decode into the result register, and the digit register
// file is updated in the same cycle as the result register, which sets the rate.
`default_nettype none

module bcd_stopwatch_display_mux #(
    parameter int NUM_DIGITS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [1:0]  digit_index,
    input  wire logic [3:0]  digit_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       digit_select,
    output logic [6:0]       segments,
    output logic             dot,
    output logic [15:0]      count_bcd
);

    localparam int SEL_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic                          in_valid_reg;
    bsdm_pkg::item_t               item_reg;
    bsdm_pkg::item_t               item_next;
    logic [NUM_DIGITS-1:0][3:0]    digits_reg;
    logic [NUM_DIGITS-1:0][3:0]    digits_next;
    logic [SEL_W-1:0]              sel_reg;
    logic [SEL_W-1:0]              sel_next;
    logic                          out_valid_reg;
    bsdm_pkg::result_t             result_reg;
    bsdm_pkg::result_t             result_next;
    logic                          advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    assign item_next.operation   = operation;
    assign item_next.digit_index = digit_index;
    assign item_next.digit_value = digit_value;

    bsdm_update #(
        .NUM_DIGITS (NUM_DIGITS),
        .SEL_W      (SEL_W)
    ) u_update (
        .item        (item_reg),
        .digits_cur  (digits_reg),
        .sel_cur     (sel_reg),
        .digits_next (digits_next),
        .sel_next    (sel_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            digits_reg    <= '0;
            sel_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                digits_reg    <= digits_next;
                sel_reg       <= sel_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign digit_select = result_reg.digit_select;
    assign segments     = result_reg.segments;
    assign dot          = result_reg.dot;
    assign count_bcd    = result_reg.count_bcd;

`ifndef SYNTHESIS
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed transaction did not reach the result register");

    a_sel_only_on_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.operation != bsdm_pkg::OP_REFRESH) |=> $stable(sel_reg))
        else $error("selected digit moved without a refresh tick");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.operation == bsdm_pkg::OP_CLEAR) |=> (digits_reg == '0))
        else $error("clear left a nonzero digit");

    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_bcd[3:0] <= 4'd9 && count_bcd[7:4] <= 4'd9 &&
                           count_bcd[11:8] <= 4'd9 && count_bcd[15:12] <= 4'd9))
        else $error("packed count holds a non-decimal digit");
`endif

endmodule

`default_nettype wire

// ===== verif/bcd_stopwatch_display_mux_tb.sv =====
`default_nettype none

module bcd_stopwatch_display_mux_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TICKS = 1300;
    localparam int QUIET_FROM   = 1100;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [1:0]          op;
        logic [1:0]          idx;
        logic [3:0]          val;
        logic                typed;
        bsdm_pkg::result_t   want;
    } tick_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [1:0]  digit_index;
    logic [3:0]  digit_value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  digit_select;
    logic [6:0]  segments;
    logic        dot;
    logic [15:0] count_bcd;

    bcd_stopwatch_display_mux dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .digit_index  (digit_index),
        .digit_value  (digit_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_select (digit_select),
        .segments     (segments),
        .dot          (dot),
        .count_bcd    (count_bcd)
    );

    // shadow copy of the display state
    logic [3:0] digit_q [4];
    logic [1:0] sel_q;

    logic [6:0] seg_shape [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    bsdm_pkg::result_t pending_displays [$];
    int      fail_count = 0;
    int      idle_cycles = 0;
    bit      quiet_tail = 1'b0;

    tick_row_t script [21] = '{
        '{bsdm_pkg::OP_COUNT,   2'd3, 4'd0,  1'b1, '{2'd0, 7'h3F, 1'b0, 16'h0001}},
        '{bsdm_pkg::OP_REFRESH, 2'd0, 4'd0,  1'b1, '{2'd1, 7'h3F, 1'b1, 16'h0001}},
        '{bsdm_pkg::OP_LOAD,    2'd0, 4'd15, 1'b1, '{2'd1, 7'h3F, 1'b1, 16'h9001}},
        '{bsdm_pkg::OP_LOAD,    2'd1, 4'd10, 1'b1, '{2'd1, 7'h6F, 1'b1, 16'h9901}},
        '{bsdm_pkg::OP_LOAD,    2'd2, 4'd9,  1'b0, '0},
        '{bsdm_pkg::OP_LOAD,    2'd3, 4'd9,  1'b0, '0},
        '{bsdm_pkg::OP_COUNT,   2'd3, 4'd0,  1'b1, '{2'd1, 7'h3F, 1'b1, 16'h0000}},
        '{bsdm_pkg::OP_LOAD,    2'd0, 4'd9,  1'b0, '0},
        '{bsdm_pkg::OP_COUNT,   2'd0, 4'd0,  1'b1, '{2'd1, 7'h3F, 1'b1, 16'h0000}},
        '{bsdm_pkg::OP_LOAD,    2'd3, 4'd9,  1'b0, '0},
        '{bsdm_pkg::OP_COUNT,   2'd3, 4'd6,  1'b0, '0},
        '{bsdm_pkg::OP_REFRESH, 2'd2, 4'd3,  1'b0, '0},
        '{bsdm_pkg::OP_REFRESH, 2'd1, 4'd12, 1'b0, '0},
        '{bsdm_pkg::OP_REFRESH, 2'd3, 4'd15, 1'b0, '0},
        '{bsdm_pkg::OP_LOAD,    2'd1, 4'd9,  1'b0, '0},
        '{bsdm_pkg::OP_LOAD,    2'd2, 4'd9,  1'b0, '0},
        '{bsdm_pkg::OP_COUNT,   2'd2, 4'd0,  1'b0, '0},
        '{bsdm_pkg::OP_LOAD,    2'd0, 4'd5,  1'b0, '0},
        '{bsdm_pkg::OP_CLEAR,   2'd3, 4'd15, 1'b1, '{2'd0, 7'h3F, 1'b0, 16'h0000}},
        '{bsdm_pkg::OP_LOAD,    2'd2, 4'd7,  1'b0, '0},
        '{bsdm_pkg::OP_COUNT,   2'd1, 4'd15, 1'b0, '0}
    };

    function automatic bsdm_pkg::result_t step_display(input bsdm_pkg::item_t it);
        bsdm_pkg::result_t r;
        int         p;
        logic [3:0] d;
        logic [3:0] shown;
        bit         carry;
        case (it.operation)
            bsdm_pkg::OP_COUNT: begin
                // ripple toward digit 0; the top digit wraps without carry
                carry = 1'b1;
                for (p = int'(it.digit_index); p >= 0 && carry; p--) begin
                    d = digit_q[p];
                    carry = (p != 0) && (d == 4'd9);
                    digit_q[p] = (d >= 4'd9) ? 4'd0 : d + 4'd1;
                end
            end
            bsdm_pkg::OP_REFRESH: sel_q = sel_q + 2'd1;
            bsdm_pkg::OP_CLEAR: begin
                for (p = 0; p < 4; p++)
                    digit_q[p] = 4'd0;
            end
            default: digit_q[it.digit_index] = (it.digit_value > 4'd9) ? 4'd9 : it.digit_value;
        endcase
        shown = (digit_q[sel_q] > 4'd9) ? 4'd9 : digit_q[sel_q];
        r.digit_select = sel_q;
        r.segments     = seg_shape[shown];
        r.dot          = (sel_q == 2'd1);
        r.count_bcd    = {digit_q[0], digit_q[1], digit_q[2], digit_q[3]};
        return r;
    endfunction

    task automatic drive_tick(input bsdm_pkg::item_t it, input logic typed,
                              input bsdm_pkg::result_t want);
        bsdm_pkg::result_t model;
        int      gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= it.operation;
        digit_index <= it.digit_index;
        digit_value <= it.digit_value;
        do @(posedge clk); while (!in_ready);
        model = step_display(it);
        pending_displays.push_back(typed ? want : model);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        bsdm_pkg::item_t it;
        int    pick;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        operation   <= bsdm_pkg::OP_COUNT;
        digit_index <= 2'd0;
        digit_value <= 4'd0;
        for (int i = 0; i < 4; i++)
            digit_q[i] = 4'd0;
        sel_q = 2'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            it.operation   = script[i].op;
            it.digit_index = script[i].idx;
            it.digit_value = script[i].val;
            drive_tick(it, script[i].typed, script[i].want);
        end

        for (int n = 0; n < RANDOM_TICKS; n++)
        begin
            quiet_tail = (n >= QUIET_FROM);
            pick = $urandom_range(0, 99);
            // favor counts and nine-heavy loads so carries ripple often
            if (pick < 45)
                it.operation = bsdm_pkg::OP_COUNT;
            else if (pick < 70)
                it.operation = bsdm_pkg::OP_REFRESH;
            else if (pick < 93)
                it.operation = bsdm_pkg::OP_LOAD;
            else
                it.operation = bsdm_pkg::OP_CLEAR;
            it.digit_index = 2'($urandom_range(0, 3));
            if (it.operation == bsdm_pkg::OP_LOAD && $urandom_range(0, 1) == 0)
                it.digit_value = 4'($urandom_range(9, 15));
            else
                it.digit_value = 4'($urandom_range(0, 15));
            drive_tick(it, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_displays.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("bcd_stopwatch_display_mux_tb OK");
        else
            $display("bcd_stopwatch_display_mux_tb NOT OK");
        $finish;
    end

    // result side backpressure in short bursts
    initial
    begin
        out_ready <= 1'b1;
        forever
        begin
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        bsdm_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_displays.size() == 0)
            begin
                $error("result transaction with nothing pending: select %0d bcd %h",
                       digit_select, count_bcd);
                fail_count++;
            end
            else
            begin
                want = pending_displays.pop_front();
                if (digit_select !== want.digit_select)
                begin
                    $error("digit_select: expected %0d, got %0d", want.digit_select, digit_select);
                    fail_count++;
                end
                if (segments !== want.segments)
                begin
                    $error("segments: expected %h, got %h", want.segments, segments);
                    fail_count++;
                end
                if (dot !== want.dot)
                begin
                    $error("dot: expected %0b, got %0b", want.dot, dot);
                    fail_count++;
                end
                if (count_bcd !== want.count_bcd)
                begin
                    $error("count_bcd: expected %h, got %h", want.count_bcd, count_bcd);
                    fail_count++;
                end
            end
        end
    end

    // end the run if neither side moves a transaction for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("bcd_stopwatch_display_mux_tb NOT OK");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
